// ----- rtl/mnva_pkg.sv -----
// Package: shared constants, types and the semitone table for the MIDI voice allocator.
`default_nettype none
package mnva_pkg;

    localparam int VOICE_COUNT = 16;
    localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VOICE_W     = 4;
    localparam int NOTE_W      = 7;
    localparam int FREQ_W      = 16;
    localparam int WAVE_W      = 5;
    localparam int STEP_W      = 3;

    // MIDI byte classes
    localparam logic [7:0] RT_MIN      = 8'hF8;
    localparam logic [7:0] CHAN_MAX    = 8'hEF;
    localparam logic [7:0] HI3_MASK    = 8'hE0;
    localparam logic [7:0] ONE_BYTE_HI = 8'hC0;
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [1:0] LEN_ONE      = 2'd1;
    localparam logic [1:0] LEN_TWO      = 2'd2;

    // voice register offsets
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_WAVE    = 3'd1;
    localparam logic [2:0] REG_FREQ_LO = 3'd2;
    localparam logic [2:0] REG_FREQ_HI = 3'd3;
    localparam logic [2:0] REG_START   = 3'd4;
    localparam logic [2:0] REG_ENV     = 3'd5;

    localparam logic [7:0] CTRL_OFF   = 8'd0;
    localparam logic [7:0] CTRL_KEYON = 8'd3;
    localparam logic [7:0] START_VAL  = 8'd0;
    localparam logic [7:0] ENV_VAL    = 8'd1;

    localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

    // octave split: note / 12 as (note * 43) >> 9, exact for 7-bit notes
    localparam logic [5:0] DIV12_MUL   = 6'd43;
    localparam int         DIV12_SHIFT = 9;
    localparam logic [3:0] OCT_REF     = 4'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } alloc_state_t;

    typedef struct packed {
        logic              valid;
        logic              note_on;
        logic [NOTE_W-1:0] note;
    } note_event_t;

    function automatic logic [FREQ_W-1:0] semitone(input logic [3:0] idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            4'd0:    f = 16'd3691;
            4'd1:    f = 16'd3911;
            4'd2:    f = 16'd4148;
            4'd3:    f = 16'd4397;
            4'd4:    f = 16'd4658;
            4'd5:    f = 16'd4935;
            4'd6:    f = 16'd5228;
            4'd7:    f = 16'd5539;
            4'd8:    f = 16'd5868;
            4'd9:    f = 16'd6217;
            4'd10:   f = 16'd6586;
            4'd11:   f = 16'd6976;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/mnva_parser.sv -----
// Running-status MIDI parser: turns accepted bytes into note on / note off events.
`default_nettype none
module mnva_parser
    import mnva_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  midi_in,
    output note_event_t      ev
);

    logic [7:0]        running_status_reg, running_status_next;
    logic [1:0]        message_length_reg, message_length_next;
    logic [1:0]        byte_count_reg, byte_count_next;
    logic [NOTE_W-1:0] first_data_reg, first_data_next;
    logic [1:0]        count_inc;
    logic [NOTE_W-1:0] note_cur;

    always_comb
    begin
        running_status_next = running_status_reg;
        message_length_next = message_length_reg;
        byte_count_next     = byte_count_reg;
        first_data_next     = first_data_reg;
        count_inc           = byte_count_reg + 2'd1;
        note_cur            = (byte_count_reg == 2'd0) ? midi_in[NOTE_W-1:0] : first_data_reg;
        ev                  = '0;
        if (accept && midi_in < RT_MIN)
        begin
            if (midi_in[7])
            begin
                byte_count_next = 2'd0;
                if (midi_in <= CHAN_MAX)
                begin
                    running_status_next = midi_in;
                    message_length_next = ((midi_in & HI3_MASK) == ONE_BYTE_HI) ? LEN_ONE : LEN_TWO;
                end
                else
                begin
                    running_status_next = 8'd0;
                end
            end
            else if (running_status_reg != 8'd0)
            begin
                first_data_next = note_cur;
                if (count_inc < message_length_reg)
                begin
                    byte_count_next = count_inc;
                end
                else
                begin
                    byte_count_next = 2'd0;
                    ev.note         = note_cur;
                    if (running_status_reg[7:4] == MSG_NOTE_OFF)
                    begin
                        ev.valid = 1'b1;
                    end
                    else if (running_status_reg[7:4] == MSG_NOTE_ON)
                    begin
                        ev.valid   = 1'b1;
                        ev.note_on = (midi_in != 8'd0);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg <= 8'd0;
            message_length_reg <= 2'd0;
            byte_count_reg     <= 2'd0;
            first_data_reg     <= '0;
        end
        else
        begin
            running_status_reg <= running_status_next;
            message_length_reg <= message_length_next;
            byte_count_reg     <= byte_count_next;
            first_data_reg     <= first_data_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mnva_freq.sv -----
// Note-to-frequency: semitone table shifted by octave, truncated to 16 bits.
`default_nettype none
module mnva_freq
    import mnva_pkg::*;
(
    input  wire logic [NOTE_W-1:0] note,
    output logic [FREQ_W-1:0]      freq
);

    logic [12:0]       prod;
    logic [3:0]        octave;
    logic [NOTE_W-1:0] oct_x12;
    logic [NOTE_W-1:0] rem;
    logic [FREQ_W-1:0] base;
    logic [20:0]       shifted;

    always_comb
    begin
        prod    = 13'(note) * 13'(DIV12_MUL);
        octave  = prod[DIV12_SHIFT +: 4];
        oct_x12 = NOTE_W'({octave, 3'b000}) + NOTE_W'({octave, 2'b00});
        rem     = note - oct_x12;
        base    = semitone(rem[3:0]);
        if (octave >= OCT_REF)
            shifted = 21'(base) << (octave - OCT_REF);
        else
            shifted = 21'(base) >> (OCT_REF - octave);
        freq = shifted[FREQ_W-1:0];
    end

endmodule
`default_nettype wire

// ----- rtl/mnva_alloc.sv -----
// Voice allocator: sequencer scanning the voice table one voice per cycle, then emitting any writes.
`default_nettype none
module mnva_alloc
    import mnva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire note_event_t       ev,
    input  wire logic [WAVE_W-1:0] wave_sel,
    output logic                   busy,
    output logic                   write_valid,
    input  wire logic              write_stall,
    output logic [VOICE_W-1:0]     voice_number,
    output logic [2:0]             register_offset,
    output logic [7:0]             data_byte,
    output logic                   last
);

    alloc_state_t state_reg, state_next;

    logic [VIDX_W-1:0]      scan_idx_reg;
    logic [NOTE_W-1:0]      note_reg;
    logic                   on_reg;
    logic                   hit_found_reg;
    logic [VIDX_W-1:0]      hit_idx_reg;
    logic                   free_found_reg;
    logic [VIDX_W-1:0]      free_idx_reg;
    logic [VIDX_W-1:0]      sel_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [VOICE_COUNT-1:0] voice_active_reg;
    logic [NOTE_W-1:0]      voice_note_reg [VOICE_COUNT];
    logic                   wr_valid_reg;
    logic [VOICE_W-1:0]     wr_voice_reg;
    logic [2:0]             wr_offset_reg;
    logic [7:0]             wr_data_reg;
    logic                   wr_last_reg;

    logic              scan_end;
    logic              match;
    logic [VIDX_W-1:0] sel_next;
    logic [FREQ_W-1:0] freq;
    logic              load;
    logic              step_last;
    logic [2:0]        cur_offset;
    logic [7:0]        cur_data;

    mnva_freq u_freq (
        .note (note_reg),
        .freq (freq)
    );

    assign scan_end = (scan_idx_reg == VIDX_W'(VOICE_COUNT - 1));
    assign match    = voice_active_reg[scan_idx_reg] && (voice_note_reg[scan_idx_reg] == note_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (ev.valid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_end) state_next = ST_DECIDE;
            ST_DECIDE: state_next = (on_reg || hit_found_reg) ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (load && step_last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        load      = (state_reg == ST_EMIT) && (!wr_valid_reg || !write_stall);
        step_last = !on_reg || (step_reg == STEP_LAST);
        if (!on_reg)
            sel_next = hit_idx_reg;
        else if (hit_found_reg)
            sel_next = hit_idx_reg;
        else if (free_found_reg)
            sel_next = free_idx_reg;
        else
            sel_next = '0;
        cur_offset = REG_CONTROL;
        cur_data   = CTRL_OFF;
        if (on_reg)
        begin
            case (step_reg)
                3'd0:
                begin
                    cur_offset = REG_CONTROL;
                    cur_data   = CTRL_OFF;
                end
                3'd1:
                begin
                    cur_offset = REG_WAVE;
                    cur_data   = 8'(wave_sel);
                end
                3'd2:
                begin
                    cur_offset = REG_FREQ_LO;
                    cur_data   = freq_reg[7:0];
                end
                3'd3:
                begin
                    cur_offset = REG_FREQ_HI;
                    cur_data   = freq_reg[15:8];
                end
                3'd4:
                begin
                    cur_offset = REG_START;
                    cur_data   = START_VAL;
                end
                3'd5:
                begin
                    cur_offset = REG_ENV;
                    cur_data   = ENV_VAL;
                end
                3'd6:
                begin
                    cur_offset = REG_CONTROL;
                    cur_data   = CTRL_KEYON;
                end
                default:
                begin
                    cur_offset = REG_CONTROL;
                    cur_data   = CTRL_OFF;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            on_reg           <= 1'b0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            step_reg         <= '0;
            voice_active_reg <= '0;
            wr_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (ev.valid)
                    begin
                        on_reg         <= ev.note_on;
                        scan_idx_reg   <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + VIDX_W'(1);
                    if (match && !hit_found_reg)
                        hit_found_reg <= 1'b1;
                    if (!voice_active_reg[scan_idx_reg] && !free_found_reg)
                        free_found_reg <= 1'b1;
                end
                ST_DECIDE:
                begin
                    step_reg <= '0;
                    if (on_reg)
                        voice_active_reg[sel_next] <= 1'b1;
                    else if (hit_found_reg)
                        voice_active_reg[hit_idx_reg] <= 1'b0;
                end
                ST_EMIT:
                begin
                    if (load)
                        step_reg <= step_reg + STEP_W'(1);
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
            if (load)
                wr_valid_reg <= 1'b1;
            else if (!write_stall)
                wr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && ev.valid)
            note_reg <= ev.note;
        if (state_reg == ST_SCAN)
        begin
            if (match && !hit_found_reg)
                hit_idx_reg <= scan_idx_reg;
            if (!voice_active_reg[scan_idx_reg] && !free_found_reg)
                free_idx_reg <= scan_idx_reg;
        end
        if (state_reg == ST_DECIDE)
        begin
            sel_reg  <= sel_next;
            freq_reg <= freq;
            if (on_reg)
                voice_note_reg[sel_next] <= note_reg;
        end
        if (load)
        begin
            wr_voice_reg  <= VOICE_W'(sel_reg);
            wr_offset_reg <= cur_offset;
            wr_data_reg   <= cur_data;
            wr_last_reg   <= step_last;
        end
    end

    assign write_valid     = wr_valid_reg;
    assign voice_number    = wr_voice_reg;
    assign register_offset = wr_offset_reg;
    assign data_byte       = wr_data_reg;
    assign last            = wr_last_reg;

`ifndef ASSERT_OFF
    a_event_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid |-> state_reg == ST_IDLE)
        else $error("event while allocator busy");

    a_active_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DECIDE |=> $stable(voice_active_reg))
        else $error("voice table changed outside decide");

    a_write_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wr_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("write word raised outside emit");

    a_scan_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_idx_reg <= VIDX_W'(VOICE_COUNT - 1))
        else $error("scan index out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/midi_note_voice_allocator.sv -----
// Top level: MIDI byte parser with voice allocation driving synth register writes.
//
// Usage:
//   Input channel  midi_in / midi_valid / midi_stall: one MIDI byte per word.
//   Output channel voice_number, register_offset, data_byte, last with
//   write_valid / write_stall: one synth register write per word; last marks
//   the final write caused by a byte.
//   Config channel wave_select / cfg_valid / cfg_ready: wavetable number,
//   always ready, write only while idle.
// Flow control:
//   A byte that ends no note message is taken without raising midi_stall.
//   A note byte holds midi_stall through the voice scan and decision, then
//   through the writes (none for a note off that finds no voice, 1 for note
//   off, 7 for note on), which wait while write_stall is high. The voice
//   table is scanned one voice per cycle.
// Reset: running status cleared, all voices idle, no write pending.
// A stalled output word holds; while writes remain, the block waits in its emit phase.
`default_nettype none
module midi_note_voice_allocator
    import mnva_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        midi_in,
    input  wire logic              midi_valid,
    output logic                   midi_stall,
    output logic [VOICE_W-1:0]     voice_number,
    output logic [2:0]             register_offset,
    output logic [7:0]             data_byte,
    output logic                   last,
    output logic                   write_valid,
    input  wire logic              write_stall,
    input  wire logic [WAVE_W-1:0] wave_select,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready
);

    logic              busy;
    logic              accept;
    note_event_t       ev;
    logic [WAVE_W-1:0] wave_select_reg;

    assign cfg_ready  = 1'b1;
    assign midi_stall = busy;
    assign accept     = midi_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_select_reg <= '0;
        else if (cfg_valid && cfg_ready)
            wave_select_reg <= wave_select;
    end

    mnva_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .midi_in (midi_in),
        .ev      (ev)
    );

    mnva_alloc u_alloc (
        .clk             (clk),
        .rst_n           (rst_n),
        .ev              (ev),
        .wave_sel        (wave_select_reg),
        .busy            (busy),
        .write_valid     (write_valid),
        .write_stall     (write_stall),
        .voice_number    (voice_number),
        .register_offset (register_offset),
        .data_byte       (data_byte),
        .last            (last)
    );

endmodule
`default_nettype wire
